@@ design/mhrd_pkg.sv @@
package mhrd_pkg;

  // default geometry
  localparam int MEDIAN_TAPS_DEF   = 5;
  localparam int HISTORY_DEPTH_DEF = 30;
  localparam int TEMP_BITS_DEF     = 12;

  // fixed field widths
  localparam int MEDIAN_BITS    = 12;
  localparam int THR_BITS       = 12;
  localparam int NEED_BITS      = 5;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 12;

  // queue depths and count tree grouping
  localparam int MID_QUEUE_DEPTH = 4;
  localparam int OUT_QUEUE_DEPTH = 4;
  localparam int GROUP_SIZE      = 8;

  // register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_TEMP_THR     = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HIGH_COUNT_NEEDED = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RISE_THR          = 2'd2;

  // register reset values
  localparam logic [THR_BITS-1:0]  HIGH_TEMP_THR_RST     = 12'd58;
  localparam logic [NEED_BITS-1:0] HIGH_COUNT_NEEDED_RST = 5'd27;
  localparam logic [THR_BITS-1:0]  RISE_THR_RST          = 12'd8;

  typedef struct packed {
    logic [THR_BITS-1:0]  high_temp_thr;
    logic [NEED_BITS-1:0] high_count_needed;
    logic [THR_BITS-1:0]  rise_thr;
  } cfg_t;

  typedef struct packed {
    logic [MEDIAN_BITS-1:0] median_value;
    logic                   median_valid;
    logic                   high_alarm;
    logic                   rise_alarm;
    logic                   alarm_latched;
  } result_t;

endpackage

@@ design/mhrd_fifo.sv @@
module mhrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             wdata,
  output logic                         full,
  input  logic                         pop,
  output logic                         empty,
  output logic [WIDTH-1:0]             rdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and count update
  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_W'(DEPTH-1)) ? '0 : wptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH-1)) ? '0 : rptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

@@ design/mhrd_front.sv @@
module mhrd_front #(
  parameter int MEDIAN_TAPS = mhrd_pkg::MEDIAN_TAPS_DEF,
  parameter int TEMP_BITS   = mhrd_pkg::TEMP_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     accept,
  input  logic [TEMP_BITS-1:0]     sample,
  output logic [2*TEMP_BITS:0]     mid_data
);

  import mhrd_pkg::*;

  localparam int FILL_W = $clog2(MEDIAN_TAPS+1);
  localparam int RANK_W = $clog2(MEDIAN_TAPS);
  localparam int MID_RANK = (MEDIAN_TAPS-1)/2;

  logic [TEMP_BITS-1:0] win_r   [MEDIAN_TAPS];
  logic [TEMP_BITS-1:0] win_nxt [MEDIAN_TAPS];
  logic [RANK_W-1:0]    rank    [MEDIAN_TAPS];
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [TEMP_BITS-1:0] med;
  logic                 med_valid;

  // window shifts the new sample in at tap zero
  always_comb begin
    win_nxt[0] = sample;
    for (int i = 1; i < MEDIAN_TAPS; i++) begin
      win_nxt[i] = win_r[i-1];
    end
    fill_nxt = (fill_r == FILL_W'(MEDIAN_TAPS)) ? fill_r : fill_r + FILL_W'(1);
  end

  // rank of each tap in ascending order, ties broken by tap position
  always_comb begin
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MEDIAN_TAPS; j++) begin
        if (j != i && ((win_nxt[j] < win_nxt[i]) ||
                       (win_nxt[j] == win_nxt[i] && j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // pick the middle rank, zero until the window is full
  always_comb begin
    med_valid = (fill_r >= FILL_W'(MEDIAN_TAPS-1));
    med       = '0;
    for (int i = 0; i < MEDIAN_TAPS; i++) begin
      if (med_valid && rank[i] == RANK_W'(MID_RANK)) begin
        med = med | win_nxt[i];
      end
    end
  end

  assign mid_data = {sample, med, med_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < MEDIAN_TAPS; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

endmodule

@@ design/mhrd_back.sv @@
module mhrd_back #(
  parameter int HISTORY_DEPTH = mhrd_pkg::HISTORY_DEPTH_DEF,
  parameter int TEMP_BITS     = mhrd_pkg::TEMP_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  mhrd_pkg::cfg_t                               cfg,
  input  logic                                         mid_empty,
  input  logic [2*TEMP_BITS:0]                         mid_data,
  output logic                                         mid_pop,
  input  logic [$clog2(mhrd_pkg::OUT_QUEUE_DEPTH+1)-1:0] out_count,
  output logic                                         res_push,
  output mhrd_pkg::result_t                            res
);

  import mhrd_pkg::*;

  localparam int HFILL_W = $clog2(HISTORY_DEPTH+1);
  localparam int CNT_W   = $clog2(HISTORY_DEPTH+1);
  localparam int OCNT_W  = $clog2(OUT_QUEUE_DEPTH+1);
  localparam int NGRP    = (HISTORY_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GS_W    = $clog2(GROUP_SIZE+1);
  localparam int CMP_W   = (TEMP_BITS > THR_BITS) ? TEMP_BITS : THR_BITS;
  localparam int RISE_W  = CMP_W + 1;
  localparam int NEED_W  = (CNT_W > NEED_BITS) ? CNT_W : NEED_BITS;
  localparam int WIDE_W  = TEMP_BITS + MEDIAN_BITS;

  // median history as a shift line, newest at tap zero
  logic [TEMP_BITS-1:0] hist_r [HISTORY_DEPTH];
  logic [HFILL_W-1:0]   hfill_r;

  logic [TEMP_BITS-1:0] d_sample, d_med;
  logic                 d_valid;
  logic                 issue, push_hist, full_after;
  logic [OCNT_W:0]      occupancy;

  // stage one
  logic                 s1_v_r;
  logic [TEMP_BITS-1:0] s1_sample_r, s1_med_r, s1_oldest_r;
  logic                 s1_valid_r, s1_full_r;

  // stage two
  logic                 s2_v_r;
  logic [GS_W-1:0]      s2_gsum_r [NGRP];
  logic [TEMP_BITS-1:0] s2_med_r;
  logic                 s2_valid_r, s2_full_r, s2_rise_r;

  logic [NGRP*GROUP_SIZE-1:0] hbit;
  logic [GS_W-1:0]            gsum [NGRP];
  logic                       rise;
  logic [CNT_W-1:0]           high_count;
  logic                       high;
  logic                       flag_r, flag_nxt;
  logic [WIDE_W-1:0]          med_wide;

  assign d_sample = mid_data[2*TEMP_BITS:TEMP_BITS+1];
  assign d_med    = mid_data[TEMP_BITS:1];
  assign d_valid  = mid_data[0];

  // issue only while the result queue has room for everything in flight
  assign occupancy  = (OCNT_W+1)'(out_count) + (OCNT_W+1)'(s1_v_r) + (OCNT_W+1)'(s2_v_r);
  assign issue      = !mid_empty && (occupancy < (OCNT_W+1)'(OUT_QUEUE_DEPTH));
  assign mid_pop    = issue;
  assign push_hist  = issue && d_valid;
  assign full_after = (hfill_r >= HFILL_W'(HISTORY_DEPTH-1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hfill_r <= '0;
    end else if (push_hist && hfill_r != HFILL_W'(HISTORY_DEPTH)) begin
      hfill_r <= hfill_r + HFILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push_hist) begin
      hist_r[0] <= d_med;
      for (int i = 1; i < HISTORY_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // stage one registers: oldest median after this push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_sample_r <= d_sample;
      s1_med_r    <= d_med;
      s1_valid_r  <= d_valid;
      s1_full_r   <= d_valid && full_after;
      s1_oldest_r <= hist_r[HISTORY_DEPTH-2];
    end
  end

  // per-entry threshold compare and group counts over the updated history
  always_comb begin
    hbit = '0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hbit[i] = (CMP_W'(hist_r[i]) >= CMP_W'(cfg.high_temp_thr));
    end
    for (int g = 0; g < NGRP; g++) begin
      gsum[g] = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        gsum[g] = gsum[g] + GS_W'(hbit[g*GROUP_SIZE+k]);
      end
    end
  end

  // rise check without going signed: sample >= oldest + threshold
  assign rise = s1_full_r &&
                (RISE_W'(s1_sample_r) >= RISE_W'(s1_oldest_r) + RISE_W'(cfg.rise_thr));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      for (int g = 0; g < NGRP; g++) begin
        s2_gsum_r[g] <= gsum[g];
      end
      s2_med_r   <= s1_med_r;
      s2_valid_r <= s1_valid_r;
      s2_full_r  <= s1_full_r;
      s2_rise_r  <= rise;
    end
  end

  // final count, high alarm and latched flag
  always_comb begin
    high_count = '0;
    for (int g = 0; g < NGRP; g++) begin
      high_count = high_count + CNT_W'(s2_gsum_r[g]);
    end
    high     = s2_full_r && (NEED_W'(high_count) >= NEED_W'(cfg.high_count_needed));
    flag_nxt = flag_r || high || s2_rise_r;
    med_wide = WIDE_W'(s2_med_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (s2_v_r) begin
      flag_r <= flag_nxt;
    end
  end

  assign res_push          = s2_v_r;
  assign res.median_value  = med_wide[MEDIAN_BITS-1:0];
  assign res.median_valid  = s2_valid_r;
  assign res.high_alarm    = high;
  assign res.rise_alarm    = s2_rise_r;
  assign res.alarm_latched = flag_nxt;

endmodule

@@ design/median_heat_rise_detector_core.sv @@
// channel   direction  handshake          payload
// in_       input      in_push / in_full  in_sample_temp
// out_      output     out_pop / out_empty median_value, median_valid, high/rise alarms, latched
// cfg_      input      cfg_wr_en          cfg_index, cfg_data
//
// one item per cycle sustained while the result queue has room; a result reaches the out_ ports
// in steps (front median into the middle queue at accept, history push, compare/group count,
// final sum into the result queue)
// the history count runs as a registered tree of eight-entry groups
// synchronous active-low reset clears fill counts, queues and the latched flag
// a stalled result side fills the result queue, then the middle queue, then raises in_full
module median_heat_rise_detector_core #(
  parameter int MEDIAN_TAPS   = mhrd_pkg::MEDIAN_TAPS_DEF,
  parameter int HISTORY_DEPTH = mhrd_pkg::HISTORY_DEPTH_DEF,
  parameter int TEMP_BITS     = mhrd_pkg::TEMP_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [TEMP_BITS-1:0]                in_sample_temp,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [mhrd_pkg::MEDIAN_BITS-1:0]    out_median_value,
  output logic                                out_median_valid,
  output logic                                out_high_alarm,
  output logic                                out_rise_alarm,
  output logic                                out_alarm_latched,
  input  logic                                cfg_wr_en,
  input  logic [mhrd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mhrd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import mhrd_pkg::*;

  localparam int MID_W  = 2*TEMP_BITS + 1;
  localparam int OCNT_W = $clog2(OUT_QUEUE_DEPTH+1);

  cfg_t              cfg_r, cfg_nxt;
  logic              accept;
  logic [MID_W-1:0]  front_data, mid_data;
  logic              mid_full, mid_empty, mid_pop;
  logic [OCNT_W-1:0] out_count;
  logic              res_push;
  result_t           res, out_res;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_HIGH_TEMP_THR:     cfg_nxt.high_temp_thr     = cfg_data[THR_BITS-1:0];
        CFG_HIGH_COUNT_NEEDED: cfg_nxt.high_count_needed = cfg_data[NEED_BITS-1:0];
        CFG_RISE_THR:          cfg_nxt.rise_thr          = cfg_data[THR_BITS-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.high_temp_thr     <= HIGH_TEMP_THR_RST;
      cfg_r.high_count_needed <= HIGH_COUNT_NEEDED_RST;
      cfg_r.rise_thr          <= RISE_THR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_full = mid_full;
  assign accept  = in_push && !mid_full;

  // front: raw window and median
  mhrd_front #(
    .MEDIAN_TAPS (MEDIAN_TAPS),
    .TEMP_BITS   (TEMP_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .sample   (in_sample_temp),
    .mid_data (front_data)
  );

  // queue between front and back
  mhrd_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_QUEUE_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_data),
    .full  (mid_full),
    .pop   (mid_pop),
    .empty (mid_empty),
    .rdata (mid_data),
    .count ()
  );

  // back: median history, counts and alarms
  mhrd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TEMP_BITS     (TEMP_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_data  (mid_data),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res       (res)
  );

  // result queue
  mhrd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_QUEUE_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_res),
    .count (out_count)
  );

  assign out_median_value  = out_res.median_value;
  assign out_median_valid  = out_res.median_valid;
  assign out_high_alarm    = out_res.high_alarm;
  assign out_rise_alarm    = out_res.rise_alarm;
  assign out_alarm_latched = out_res.alarm_latched;

endmodule

@@ tb/sv/median_heat_rise_detector_core_tb.sv @@
`timescale 1ns / 100ps

module median_heat_rise_detector_core_tb;
  import mhrd_pkg::*;

  localparam int MEDIAN_TAPS    = MEDIAN_TAPS_DEF;
  localparam int HISTORY_DEPTH  = HISTORY_DEPTH_DEF;
  localparam int TEMP_BITS      = TEMP_BITS_DEF;
  localparam int MEDIAN_MID     = (MEDIAN_TAPS - 1) / 2;
  localparam int TEMP_MAX       = (1 << TEMP_BITS) - 1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int BACKLOG_CYCLES = 200;
  localparam int PRINT_LIMIT    = 50;
  localparam int RUN_LIMIT_NS   = 5_000_000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED_INDEX = 2'd3;

  // dut ports, inputs known from time zero
  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_push = 1'b0;
  logic                      in_full;
  logic [TEMP_BITS-1:0]      in_sample_temp = '0;
  logic                      out_empty;
  logic                      out_pop = 1'b0;
  logic [MEDIAN_BITS-1:0]    out_median_value;
  logic                      out_median_valid;
  logic                      out_high_alarm;
  logic                      out_rise_alarm;
  logic                      out_alarm_latched;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // detector registers as the predictor sees them
  logic [THR_BITS-1:0]  high_temp_thr;
  logic [NEED_BITS-1:0] count_needed;
  logic [THR_BITS-1:0]  rise_thr;

  // detector state as the predictor sees it
  logic [TEMP_BITS-1:0]   raw_window [MEDIAN_TAPS];
  logic [MEDIAN_BITS-1:0] median_history [HISTORY_DEPTH];
  int                     raw_fill;
  int                     raw_slot;
  int                     history_fill;
  int                     history_slot;
  logic                   alarm_seen;

  // item traffic and bookkeeping
  logic [TEMP_BITS-1:0] pending_samples [$];
  result_t              expected_readings [$];
  logic                 offer_taken = 1'b0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;
  int                   backlog_requests = 0;
  int                   backlog_served = 0;
  int                   hold_left = 0;
  int                   samples_taken = 0;
  int                   readings_checked = 0;
  int                   register_writes = 0;
  int                   high_alarms_seen = 0;
  int                   rise_alarms_seen = 0;
  int                   mismatch_count = 0;

  median_heat_rise_detector_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_sample_temp    (in_sample_temp),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_median_value  (out_median_value),
    .out_median_valid  (out_median_valid),
    .out_high_alarm    (out_high_alarm),
    .out_rise_alarm    (out_rise_alarm),
    .out_alarm_latched (out_alarm_latched),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // advance the detector by one sample and return the reading it gives
  function automatic result_t predict_reading(input logic [TEMP_BITS-1:0] sample);
    result_t              r;
    logic [TEMP_BITS-1:0] sorted [MEDIAN_TAPS];
    logic [TEMP_BITS-1:0] v;
    int                   i;
    int                   j;
    int                   high_seen;
    int                   rise_diff;
    r = '0;
    raw_window[raw_slot] = sample;
    raw_slot = (raw_slot + 1 >= MEDIAN_TAPS) ? 0 : raw_slot + 1;
    if (raw_fill < MEDIAN_TAPS) raw_fill++;
    if (raw_fill >= MEDIAN_TAPS) begin
      // insertion sort of the raw window, middle element is the median
      for (i = 0; i < MEDIAN_TAPS; i++) begin
        v = raw_window[i];
        j = i;
        while (j > 0 && sorted[j-1] > v) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      r.median_valid = 1'b1;
      r.median_value = MEDIAN_BITS'(sorted[MEDIAN_MID]);
      median_history[history_slot] = r.median_value;
      history_slot = (history_slot + 1 >= HISTORY_DEPTH) ? 0 : history_slot + 1;
      if (history_fill < HISTORY_DEPTH) history_fill++;
      // recount against the current threshold every time
      high_seen = 0;
      for (i = 0; i < history_fill; i++) begin
        if (median_history[i] >= high_temp_thr) high_seen++;
      end
      if (history_fill >= HISTORY_DEPTH) begin
        // slot now points at the oldest median
        rise_diff = int'(sample) - int'(median_history[history_slot]);
        r.high_alarm = (high_seen >= int'(count_needed));
        r.rise_alarm = (rise_diff >= int'(rise_thr));
        if (r.high_alarm || r.rise_alarm) alarm_seen = 1'b1;
      end
    end
    r.alarm_latched = alarm_seen;
    if (r.high_alarm) high_alarms_seen++;
    if (r.rise_alarm) rise_alarms_seen++;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic logic [TEMP_BITS-1:0] clamp_temp(input int t);
    if (t < 0) return '0;
    if (t > TEMP_MAX) return TEMP_BITS'(TEMP_MAX);
    return TEMP_BITS'(t);
  endfunction

  // queue one stretch of sensor behavior around the current threshold
  function automatic int add_segment(input int kind);
    int len;
    int noise;
    int step;
    int level;
    int k;
    len = $urandom_range(10, 40);
    noise = $urandom_range(0, 3);
    step = $urandom_range(1, 12);
    if ($urandom_range(0, 4) == 0) level = $urandom_range(0, TEMP_MAX);
    else level = int'(high_temp_thr) + int'($urandom_range(0, 160)) - 80;
    case (kind)
      0, 1, 2, 3: begin
        // steady temperature with small jitter
        for (k = 0; k < len; k++)
          pending_samples.push_back(clamp_temp(level + int'($urandom_range(0, 2 * noise)) - noise));
      end
      4, 5: begin
        // heating up
        for (k = 0; k < len; k++) pending_samples.push_back(clamp_temp(level + k * step));
      end
      6: begin
        // cooling down
        for (k = 0; k < len; k++) pending_samples.push_back(clamp_temp(level - k * step));
      end
      7: begin
        // steady with random outliers the median should reject
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 5) == 0) pending_samples.push_back(TEMP_BITS'($urandom));
          else pending_samples.push_back(clamp_temp(level));
        end
      end
      8: begin
        // raw noise over the full range
        len = $urandom_range(1, 8);
        for (k = 0; k < len; k++) pending_samples.push_back(TEMP_BITS'($urandom));
      end
      default: begin
        // cold history then full-scale jump
        len = HISTORY_DEPTH + MEDIAN_TAPS + 3;
        for (k = 0; k < len - 3; k++) pending_samples.push_back('0);
        for (k = 0; k < 3; k++) pending_samples.push_back(TEMP_BITS'(TEMP_MAX));
      end
    endcase
    return len;
  endfunction

  function automatic void fill_random(input int count);
    int added;
    added = 0;
    while (added < count) added += add_segment($urandom_range(0, 9));
  endfunction

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_HIGH_TEMP_THR:     high_temp_thr = data[THR_BITS-1:0];
      CFG_HIGH_COUNT_NEEDED: count_needed = data[NEED_BITS-1:0];
      CFG_RISE_THR:          rise_thr = data[THR_BITS-1:0];
      default: ;
    endcase
    register_writes++;
  endtask

  // wait until every item is in and every reading is out, then let the pipe settle
  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_readings.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // sender: offer the oldest pending item, hold it until taken
  always @(negedge clk) begin
    if (in_push && !offer_taken) begin
      in_push <= 1'b1;
    end else if (rst_n && pending_samples.size() != 0 &&
                 $urandom_range(0, 99) >= send_idle_pct) begin
      in_push <= 1'b1;
      in_sample_temp <= pending_samples[0];
    end else begin
      in_push <= 1'b0;
    end
  end

  // receiver: random pops, long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (backlog_served != backlog_requests) begin
      backlog_served <= backlog_requests;
      hold_left <= BACKLOG_CYCLES;
      out_pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop <= 1'b0;
    end else begin
      out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: check taken readings, predict for taken items
  always @(posedge clk) begin
    result_t want;
    offer_taken <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (expected_readings.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: reading with none expected, expected none actual median %0d",
                     $time, out_median_value);
        end else begin
          want = expected_readings.pop_front();
          compare_field("median_value", want.median_value, out_median_value);
          compare_field("median_valid", want.median_valid, out_median_valid);
          compare_field("high_alarm", want.high_alarm, out_high_alarm);
          compare_field("rise_alarm", want.rise_alarm, out_rise_alarm);
          compare_field("alarm_latched", want.alarm_latched, out_alarm_latched);
          readings_checked++;
        end
      end
      if (in_push && !in_full) begin
        expected_readings.push_back(predict_reading(in_sample_temp));
        void'(pending_samples.pop_front());
        samples_taken++;
      end
    end
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: timeout with %0d readings outstanding", $time, expected_readings.size());
    $display("median_heat_rise_detector_core_tb: FAIL");
    $finish;
  end

  // stimulus sequence
  initial begin
    logic [TEMP_BITS-1:0] directed_temps [20];
    int                   i;
    directed_temps = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095,
                       12'd1, 12'd2048, 12'd2047, 12'hAAA, 12'h555, 12'd57, 12'd58,
                       12'd59, 12'd4094, 12'd58, 12'd58, 12'd3, 12'd0};
    high_temp_thr = HIGH_TEMP_THR_RST;
    count_needed = HIGH_COUNT_NEEDED_RST;
    rise_thr = RISE_THR_RST;
    for (i = 0; i < MEDIAN_TAPS; i++) raw_window[i] = '0;
    for (i = 0; i < HISTORY_DEPTH; i++) median_history[i] = '0;
    raw_fill = 0;
    raw_slot = 0;
    history_fill = 0;
    history_slot = 0;
    alarm_seen = 1'b0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes while the windows fill, then random
    send_idle_pct = 27;
    recv_idle_pct = 52;
    for (i = 0; i < 20; i++) pending_samples.push_back(directed_temps[i]);
    wait_drained();
    fill_random(300);
    backlog_requests++;
    wait_drained();

    // everything counts as high, any non-negative rise alarms
    write_register(CFG_HIGH_TEMP_THR, '0);
    write_register(CFG_HIGH_COUNT_NEEDED, CFG_DATA_BITS'(HISTORY_DEPTH));
    write_register(CFG_RISE_THR, '0);
    fill_random(300);
    wait_drained();

    // top thresholds, zero count needed
    send_idle_pct = 52;
    recv_idle_pct = 27;
    write_register(CFG_HIGH_TEMP_THR, CFG_DATA_BITS'(TEMP_MAX));
    write_register(CFG_HIGH_COUNT_NEEDED, '0);
    write_register(CFG_RISE_THR, CFG_DATA_BITS'(TEMP_MAX));
    void'(add_segment(9));
    fill_random(250);
    wait_drained();

    // unused index, count needed beyond the history, sender pause mid-phase
    write_register(CFG_UNUSED_INDEX, CFG_DATA_BITS'($urandom));
    write_register(CFG_HIGH_TEMP_THR, 12'd100);
    write_register(CFG_HIGH_COUNT_NEEDED, 12'hFFF);
    write_register(CFG_RISE_THR, 12'd12);
    fill_random(150);
    wait_drained();
    fill_random(150);
    wait_drained();

    // random settings, no random idling, one receiver backlog in the first round
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (i = 0; i < 2; i++) begin
      write_register(CFG_HIGH_TEMP_THR, CFG_DATA_BITS'($urandom_range(0, TEMP_MAX)));
      write_register(CFG_HIGH_COUNT_NEEDED, CFG_DATA_BITS'($urandom_range(0, HISTORY_DEPTH)));
      write_register(CFG_RISE_THR, CFG_DATA_BITS'($urandom_range(0, 48)));
      fill_random(300);
      if (i == 0) backlog_requests++;
      wait_drained();
    end

    $display("covered %0d samples and %0d readings across %0d register writes",
             samples_taken, readings_checked, register_writes);
    $display("alarms expected: %0d high, %0d rise; mismatches: %0d",
             high_alarms_seen, rise_alarms_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("median_heat_rise_detector_core_tb: PASS");
    end else begin
      $display("median_heat_rise_detector_core_tb: FAIL");
    end
    $finish;
  end

endmodule
